// ===== rtl/psrl_pkg.sv =====
// Shared types, constants and codes for the per-source rate limit blocker.
package psrl_pkg;

    localparam int TABLE_ENTRIES_DEF = 1024;

    localparam int          ADDR_W     = 32;
    localparam int          TIME_W     = 64;
    localparam int          LEN_W      = 40;
    localparam int          THR_W      = 16;
    localparam int          CNT_W      = 17;
    localparam int          CFG_IDX_W  = 2;
    localparam logic [CNT_W-1:0] COUNT_MAX = '1;

    localparam logic [THR_W-1:0] THRESHOLD_RST = 16'd250;
    localparam logic [LEN_W-1:0] WINDOW_RST    = 40'd1000000000;
    localparam logic [LEN_W-1:0] BLOCK_RST     = 40'd60000000000;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_THRESHOLD = 2'd0,
        CFG_WINDOW    = 2'd1,
        CFG_BLOCK     = 2'd2
    } t_cfg_idx;

    typedef enum logic [1:0] {
        V_PASS     = 2'd0,
        V_REDIRECT = 2'd1,
        V_ABORT    = 2'd2
    } t_verdict;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_EVAL_A,
        S_EVAL_B,
        S_COMMIT,
        S_INSERT
    } t_state;

    // One table entry as it is kept in the RAM.
    typedef struct packed {
        logic [ADDR_W-1:0] key;
        logic [TIME_W-1:0] window_start;
        logic [TIME_W-1:0] block_end;
        logic [CNT_W-1:0]  count;
        logic              active;
    } t_entry;

    typedef struct packed {
        logic load;
        logic scan;
        logic eval_a;
        logic eval_b;
        logic commit_hit;
        logic commit_miss;
    } t_cmd;

    typedef struct packed {
        logic hit;
        logic miss;
    } t_status;

endpackage

// ===== rtl/per_source_rate_limit_blocker.sv =====
// Top level of the per-source rate limit blocker.
//
//  channel   direction  handshake                 word
//  packet    in         i_start, o_busy           i_source_address, i_now_ns
//  result    out        o_valid (one-cycle strobe) o_verdict, o_block_started
//  config    in         i_cfg_valid, o_cfg_ready  i_cfg_index, i_cfg_data
//
// A packet's source is looked up by a table scan, which reads one slot per
// cycle from the RAM; a known source then goes through evaluation and
// commit, while a new or rejected source goes straight to the insert step.
// Synchronous reset empties the table at once through the fill count.
// The result cannot be stalled; o_busy falls in the cycle of the strobe.
module per_source_rate_limit_blocker #(
    parameter int TABLE_ENTRIES = psrl_pkg::TABLE_ENTRIES_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    output logic                           o_busy,
    input  logic [psrl_pkg::ADDR_W-1:0]    i_source_address,
    input  logic [psrl_pkg::TIME_W-1:0]    i_now_ns,
    output logic                           o_valid,
    output logic [1:0]                     o_verdict,
    output logic                           o_block_started,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [psrl_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [psrl_pkg::LEN_W-1:0]     i_cfg_data
);
    import psrl_pkg::*;

    localparam int IW = $clog2(TABLE_ENTRIES);

    t_cmd             cmd;
    t_status          status;
    logic             busy;
    logic             ram_we;
    logic [IW-1:0]    ram_waddr;
    t_entry           ram_wdata;
    logic             ram_re;
    logic [IW-1:0]    ram_raddr;
    t_entry           ram_rdata;

    assign o_busy      = busy;
    assign o_cfg_ready = 1'b1;

    psrl_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (i_start),
        .i_status (status),
        .o_cmd    (cmd),
        .o_busy   (busy)
    );

    psrl_dp #(
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .o_status         (status),
        .i_source_address (i_source_address),
        .i_now_ns         (i_now_ns),
        .i_cfg_we         (i_cfg_valid),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .o_ram_we         (ram_we),
        .o_ram_waddr      (ram_waddr),
        .o_ram_wdata      (ram_wdata),
        .o_ram_re         (ram_re),
        .o_ram_raddr      (ram_raddr),
        .i_ram_rdata      (ram_rdata),
        .o_valid          (o_valid),
        .o_verdict        (o_verdict),
        .o_block_started  (o_block_started)
    );

    psrl_ram #(
        .WIDTH ($bits(t_entry)),
        .DEPTH (TABLE_ENTRIES)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

endmodule

// ===== rtl/psrl_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module psrl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/psrl_ctrl.sv =====
// Sequencer for lookup, evaluation and update of one packet.
module psrl_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  psrl_pkg::t_status i_status,
    output psrl_pkg::t_cmd   o_cmd,
    output logic             o_busy
);
    import psrl_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) n_state = S_SCAN;
            end
            S_SCAN: begin
                if (i_status.hit) begin
                    n_state = S_EVAL_A;
                end else if (i_status.miss) begin
                    n_state = S_INSERT;
                end
            end
            S_EVAL_A: n_state = S_EVAL_B;
            S_EVAL_B: n_state = S_COMMIT;
            S_COMMIT: n_state = S_IDLE;
            S_INSERT: n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd  = '0;
        o_busy = 1'b1;
        unique case (r_state)
            S_IDLE: begin
                o_busy     = 1'b0;
                o_cmd.load = i_start;
            end
            S_SCAN:   o_cmd.scan        = 1'b1;
            S_EVAL_A: o_cmd.eval_a      = 1'b1;
            S_EVAL_B: o_cmd.eval_b      = 1'b1;
            S_COMMIT: o_cmd.commit_hit  = 1'b1;
            S_INSERT: o_cmd.commit_miss = 1'b1;
            default:  o_busy = 1'b1;
        endcase
    end

endmodule

// ===== rtl/psrl_dp.sv =====
// Datapath: configuration registers, table scan, time checks and entry update.
module psrl_dp #(
    parameter int TABLE_ENTRIES = psrl_pkg::TABLE_ENTRIES_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  psrl_pkg::t_cmd                       i_cmd,
    output psrl_pkg::t_status                    o_status,
    input  logic [psrl_pkg::ADDR_W-1:0]          i_source_address,
    input  logic [psrl_pkg::TIME_W-1:0]          i_now_ns,
    input  logic                                 i_cfg_we,
    input  logic [psrl_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [psrl_pkg::LEN_W-1:0]           i_cfg_data,
    output logic                                 o_ram_we,
    output logic [$clog2(TABLE_ENTRIES)-1:0]     o_ram_waddr,
    output psrl_pkg::t_entry                     o_ram_wdata,
    output logic                                 o_ram_re,
    output logic [$clog2(TABLE_ENTRIES)-1:0]     o_ram_raddr,
    input  psrl_pkg::t_entry                     i_ram_rdata,
    output logic                                 o_valid,
    output logic [1:0]                           o_verdict,
    output logic                                 o_block_started
);
    import psrl_pkg::*;

    localparam int IW = $clog2(TABLE_ENTRIES);
    localparam int FW = $clog2(TABLE_ENTRIES + 1);

    logic [THR_W-1:0]  r_threshold;
    logic [LEN_W-1:0]  r_window_len;
    logic [LEN_W-1:0]  r_block_len;

    logic [FW-1:0]     r_fill;
    logic [FW-1:0]     r_idx;
    logic [IW-1:0]     r_pidx;
    logic              r_pend;
    logic [IW-1:0]     r_slot;
    logic [ADDR_W-1:0] r_src;
    logic [TIME_W-1:0] r_now;
    t_entry            r_ent;

    logic              r_blocked;
    logic [TIME_W-1:0] r_diff;
    logic [CNT_W-1:0]  r_cnt_inc;
    logic              r_in_win;
    logic              r_over;
    logic [TIME_W-1:0] r_new_end;

    logic              r_valid;
    t_verdict          r_verdict;
    logic              r_started;

    logic              issue;
    logic              hit;
    logic              full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_threshold  <= THRESHOLD_RST;
            r_window_len <= WINDOW_RST;
            r_block_len  <= BLOCK_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_THRESHOLD: r_threshold  <= i_cfg_data[THR_W-1:0];
                CFG_WINDOW:    r_window_len <= i_cfg_data;
                CFG_BLOCK:     r_block_len  <= i_cfg_data;
                default:       r_threshold  <= r_threshold;
            endcase
        end
    end

    // Slots fill in order and are never freed, so a slot is in use exactly
    // when its index is below the fill count.
    assign issue = i_cmd.scan && (r_idx < r_fill);
    assign hit   = r_pend && (i_ram_rdata.key == r_src);
    assign full  = (r_fill == FW'(TABLE_ENTRIES));

    assign o_status.hit  = hit;
    assign o_status.miss = !hit && !r_pend && !(r_idx < r_fill);

    assign o_ram_re    = issue;
    assign o_ram_raddr = r_idx[IW-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= 1'b0;
            r_fill <= '0;
        end else begin
            if (i_cmd.load) begin
                r_pend <= 1'b0;
            end else if (i_cmd.scan) begin
                r_pend <= issue;
            end
            if (i_cmd.commit_miss && !full) begin
                r_fill <= r_fill + FW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_src <= i_source_address;
            r_now <= i_now_ns;
            r_idx <= '0;
        end else if (issue) begin
            r_idx  <= r_idx + FW'(1);
            r_pidx <= r_idx[IW-1:0];
        end
        if (i_cmd.scan && hit) begin
            r_ent  <= i_ram_rdata;
            r_slot <= r_pidx;
        end
        if (i_cmd.eval_a) begin
            r_blocked <= r_ent.active && (r_now < r_ent.block_end);
            r_diff    <= r_now - r_ent.window_start;
            r_cnt_inc <= (r_ent.count == COUNT_MAX) ? r_ent.count
                                                    : r_ent.count + CNT_W'(1);
        end
        if (i_cmd.eval_b) begin
            r_in_win  <= (r_diff[TIME_W-1:LEN_W] == '0) &&
                         (r_diff[LEN_W-1:0] < r_window_len);
            r_over    <= r_cnt_inc > {1'b0, r_threshold};
            r_new_end <= r_now + {{(TIME_W-LEN_W){1'b0}}, r_block_len};
        end
    end

    // Entry update for a known or a new source; the verdict is registered below.
    always_comb begin
        o_ram_we    = 1'b0;
        o_ram_waddr = r_slot;
        o_ram_wdata = r_ent;
        if (i_cmd.commit_hit && !r_blocked) begin
            o_ram_we = 1'b1;
            if (r_in_win) begin
                o_ram_wdata.count = r_cnt_inc;
                if (r_over) begin
                    o_ram_wdata.block_end = r_new_end;
                    o_ram_wdata.active    = 1'b1;
                end
            end else begin
                o_ram_wdata.window_start = r_now;
                o_ram_wdata.count        = CNT_W'(1);
                o_ram_wdata.block_end    = '0;
                o_ram_wdata.active       = 1'b0;
            end
        end else if (i_cmd.commit_miss && !full) begin
            o_ram_we                 = 1'b1;
            o_ram_waddr              = r_fill[IW-1:0];
            o_ram_wdata.key          = r_src;
            o_ram_wdata.window_start = r_now;
            o_ram_wdata.count        = CNT_W'(1);
            o_ram_wdata.block_end    = '0;
            o_ram_wdata.active       = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_cmd.commit_hit || i_cmd.commit_miss;
        end
        if (i_cmd.commit_hit) begin
            if (r_blocked) begin
                r_verdict <= V_REDIRECT;
                r_started <= 1'b0;
            end else if (r_in_win && r_over) begin
                r_verdict <= V_REDIRECT;
                r_started <= 1'b1;
            end else begin
                r_verdict <= V_PASS;
                r_started <= 1'b0;
            end
        end else if (i_cmd.commit_miss) begin
            r_verdict <= full ? V_ABORT : V_PASS;
            r_started <= 1'b0;
        end
    end

    assign o_valid         = r_valid;
    assign o_verdict       = r_verdict;
    assign o_block_started = r_started;

endmodule

// ===== rtl/psrl_checker.sv =====
// Port-level checks for the per-source rate limit blocker, bound to the top.
module psrl_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_start,
    input logic       o_busy,
    input logic       o_valid,
    input logic [1:0] o_verdict,
    input logic       o_block_started
);
    import psrl_pkg::*;

    // An accepted word keeps the block busy until its result is produced.
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy) |=> o_busy)
        else $error("block not busy after accepting a word");

    // Each word passes through the scan and a commit or insert state, so results never come back to back.
    a_no_double: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("two result strobes in a row");

    // A block start comes with a redirect result; the result fields hold their last value between strobes.
    a_started_redirect: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_block_started) |-> (o_verdict == V_REDIRECT))
        else $error("block start without a redirect result");

    a_verdict_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_verdict == V_PASS || o_verdict == V_REDIRECT ||
                     o_verdict == V_ABORT))
        else $error("result with an undefined verdict");

    // A result only appears while the block is finishing a word.
    a_valid_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(o_busy))
        else $error("result strobe without a word in flight");

endmodule

bind per_source_rate_limit_blocker psrl_checker u_psrl_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_start         (i_start),
    .o_busy          (o_busy),
    .o_valid         (o_valid),
    .o_verdict       (o_verdict),
    .o_block_started (o_block_started)
);
